// ----- sv/hidkm_pkg.sv -----
// ----------------------------------------------------------------------------
// hidkm_pkg
// Shared types and constants for the HID report to key matrix converter.
// ----------------------------------------------------------------------------
package hidkm_pkg;

  localparam int RowCount   = 8;
  localparam int LaneCount  = 6;
  localparam int MapEntries = 256;

  // operation codes
  localparam logic [1:0] OpUpdate = 2'd0;
  localparam logic [1:0] OpRead   = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

  localparam int         ShiftModBit    = 1;
  localparam logic [7:0] ShiftClearMask = 8'hfc;

  typedef logic [7:0] row_t;
  typedef row_t [RowCount-1:0] matrix_t;

  // what one lane decoded from its usage code
  typedef struct packed {
    matrix_t rows;
    logic    suppress;
  } lane_out_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       changed;
    logic       pending;
  } result_t;

endpackage

// ----- sv/hidkm_lane.sv -----
// ----------------------------------------------------------------------------
// hidkm_lane
// Decodes one HID usage code into matrix row bits and a shift suppress flag.
// ----------------------------------------------------------------------------
module hidkm_lane (
  input  logic                 shift,
  input  logic [7:0]           code,
  output hidkm_pkg::lane_out_t lane_out
);
  import hidkm_pkg::*;

  localparam logic [7:0] KeyA       = 8'h04;
  localparam logic [7:0] KeyZ       = 8'h1d;
  localparam logic [7:0] Key1       = 8'h1e;
  localparam logic [7:0] Key2       = 8'h1f;
  localparam logic [7:0] Key6       = 8'h23;
  localparam logic [7:0] Key7       = 8'h24;
  localparam logic [7:0] Key8       = 8'h25;
  localparam logic [7:0] Key9       = 8'h26;
  localparam logic [7:0] Key0       = 8'h27;
  localparam logic [7:0] KeyEnter   = 8'h28;
  localparam logic [7:0] KeyEsc     = 8'h29;
  localparam logic [7:0] KeyBksp    = 8'h2a;
  localparam logic [7:0] KeySpace   = 8'h2c;
  localparam logic [7:0] KeyMinus   = 8'h2d;
  localparam logic [7:0] KeyEqual   = 8'h2e;
  localparam logic [7:0] KeySemi    = 8'h33;
  localparam logic [7:0] KeyQuote   = 8'h34;
  localparam logic [7:0] KeyComma   = 8'h36;
  localparam logic [7:0] KeyPeriod  = 8'h37;
  localparam logic [7:0] KeySlash   = 8'h38;
  localparam logic [7:0] KeyCaps    = 8'h3a;
  localparam logic [7:0] KeyRight   = 8'h4f;
  localparam logic [7:0] KeyLeft    = 8'h50;
  localparam logic [7:0] KeyDown    = 8'h51;
  localparam logic [7:0] KeyUp      = 8'h52;
  localparam logic [7:0] KeyLCtrl   = 8'he0;
  localparam logic [7:0] KeyLShift  = 8'he1;
  localparam logic [7:0] KeyRCtrl   = 8'he4;
  localparam logic [7:0] KeyRShift  = 8'he5;

  logic [7:0] letter_n;
  logic [7:0] digit_n;

  assign letter_n = code - 8'h03;
  assign digit_n  = code - 8'h1d;

  always_comb begin
    lane_out = '0;
    priority if (code >= KeyA && code <= KeyZ) begin
      lane_out.rows[letter_n[5:3]][letter_n[2:0]] = 1'b1;
    end else if (code == Key2 && shift) begin
      lane_out.rows[0][0] = 1'b1;
      lane_out.suppress   = 1'b1;
    end else if (code == Key6 && shift) begin
      lane_out.suppress   = 1'b1;
    end else if (code == Key7 && shift) begin
      lane_out.rows[4][6] = 1'b1;
    end else if (code == Key8 && shift) begin
      lane_out.rows[5][2] = 1'b1;
    end else if (code == Key9 && shift) begin
      lane_out.rows[5][0] = 1'b1;
      lane_out.rows[7][0] = 1'b1;
    end else if (code == Key0 && shift) begin
      lane_out.rows[5][1] = 1'b1;
      lane_out.rows[7][0] = 1'b1;
    end else if (code >= Key1 && code <= Key9) begin
      // digits 1..9 land in rows four and five
      lane_out.rows[{2'b10, digit_n[3]}][digit_n[2:0]] = 1'b1;
    end else if (code == Key0) begin
      lane_out.rows[4][0] = 1'b1;
    end else if (code == KeySemi && !shift) begin
      lane_out.rows[5][3] = 1'b1;
      lane_out.suppress   = 1'b1;
    end else if (code == KeySemi) begin
      lane_out.rows[5][2] = 1'b1;
      lane_out.suppress   = 1'b1;
    end else if (code == KeyQuote && shift) begin
      lane_out.rows[4][2] = 1'b1;
      lane_out.rows[7][0] = 1'b1;
    end else if (code == KeyComma) begin
      lane_out.rows[5][4] = 1'b1;
    end else if (code == KeyPeriod) begin
      lane_out.rows[5][6] = 1'b1;
    end else if (code == KeyEqual && !shift) begin
      lane_out.rows[5][5] = 1'b1;
      lane_out.rows[7][0] = 1'b1;
    end else if (code == KeyEqual) begin
      lane_out.rows[5][3] = 1'b1;
      lane_out.rows[7][0] = 1'b1;
    end else if (code == KeyMinus && !shift) begin
      lane_out.rows[5][5] = 1'b1;
      lane_out.suppress   = 1'b1;
    end else if (code == KeySlash) begin
      lane_out.rows[5][7] = 1'b1;
    end else if (code == KeyEnter) begin
      lane_out.rows[6][0] = 1'b1;
    end else if (code == KeyBksp) begin
      lane_out.rows[6][5] = 1'b1;
    end else if (code == KeyEsc) begin
      lane_out.rows[6][2] = 1'b1;
    end else if (code == KeyUp) begin
      lane_out.rows[6][3] = 1'b1;
    end else if (code == KeyDown) begin
      lane_out.rows[6][4] = 1'b1;
    end else if (code == KeyLeft) begin
      lane_out.rows[6][5] = 1'b1;
    end else if (code == KeyRight) begin
      lane_out.rows[6][6] = 1'b1;
    end else if (code == KeySpace) begin
      lane_out.rows[6][7] = 1'b1;
    end else if (code == KeyCaps) begin
      lane_out.rows[6][1] = 1'b1;
    end else if (code == KeyLShift) begin
      lane_out.rows[7][0] = 1'b1;
    end else if (code == KeyRShift) begin
      lane_out.rows[7][1] = 1'b1;
    end else if (code == KeyLCtrl || code == KeyRCtrl) begin
      lane_out.rows[7][4] = 1'b1;
    end else begin
      lane_out = '0;
    end
  end

endmodule

// ----- sv/hidkm_merge.sv -----
// ----------------------------------------------------------------------------
// hidkm_merge
// Merges lane outputs, holds the matrix rows and pending flag, forms results.
// ----------------------------------------------------------------------------
module hidkm_merge (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     accept,
  input  logic [1:0]                               operation,
  input  logic [7:0]                               read_address,
  input  hidkm_pkg::lane_out_t [hidkm_pkg::LaneCount-1:0] lanes,
  output hidkm_pkg::result_t                       result
);
  import hidkm_pkg::*;

  localparam logic [7:0] AddrMask = 8'(MapEntries - 1);

  matrix_t matrix_rows;
  logic    changes_pending;

  matrix_t merged;
  logic    suppress;
  logic    differs;
  logic [7:0] addr;
  row_t    read_or;
  logic    pending_next;

  always_comb begin
    merged   = '0;
    suppress = 1'b0;
    for (int l = 0; l < LaneCount; l++) begin
      merged   = merged | lanes[l].rows;
      suppress = suppress | lanes[l].suppress;
    end
    if (suppress) begin
      merged[RowCount-1] = merged[RowCount-1] & ShiftClearMask;
    end
  end

  assign differs = (merged != matrix_rows);
  assign addr    = read_address & AddrMask;

  always_comb begin
    read_or = '0;
    for (int r = 0; r < RowCount; r++) begin
      if (addr[r]) begin
        read_or = read_or | matrix_rows[r];
      end
    end
  end

  always_comb begin
    result       = '0;
    pending_next = changes_pending;
    unique case (operation)
      OpUpdate: begin
        result.changed = differs;
        pending_next   = changes_pending | differs;
      end
      OpRead: begin
        result.read_data = read_or;
      end
      OpClear: begin
        pending_next = 1'b0;
      end
      default: begin
        pending_next = changes_pending;
      end
    endcase
    result.pending = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_rows     <= '0;
      changes_pending <= 1'b0;
    end else if (accept) begin
      changes_pending <= pending_next;
      if (operation == OpUpdate) begin
        matrix_rows <= merged;
      end
    end
  end

endmodule

// ----- sv/usb_hid_to_key_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// usb_hid_to_key_matrix_unit
// Converts boot-keyboard reports into an 8x8 key matrix, reads matrix bytes
// and clears the pending-change flag.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   operation, modifiers, key_code_0..5,
//                                read_address
//   out      out_valid/out_stall read_data, changed, pending
//
// one transfer per cycle sustained while out_stall stays low; each result is
// registered. six decode lanes run in parallel and merge combinationally.
// a two-entry output buffer (register plus skid) lets input continue while
// a result waits; in_stall rises only when both entries are full.
// synchronous reset clears the matrix, the pending flag and the buffer.
// ----------------------------------------------------------------------------
module usb_hid_to_key_matrix_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] modifiers,
  input  logic [7:0] key_code_0,
  input  logic [7:0] key_code_1,
  input  logic [7:0] key_code_2,
  input  logic [7:0] key_code_3,
  input  logic [7:0] key_code_4,
  input  logic [7:0] key_code_5,
  input  logic [7:0] read_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       changed,
  output logic       pending
);
  import hidkm_pkg::*;

  logic [LaneCount-1:0][7:0] codes;
  lane_out_t [LaneCount-1:0] lanes;
  result_t   result;
  result_t   out_res;
  result_t   skid_res;
  logic      skid_valid;
  logic      accept;

  assign codes = {key_code_5, key_code_4, key_code_3,
                  key_code_2, key_code_1, key_code_0};

  for (genvar l = 0; l < LaneCount; l++) begin : g_lane
    hidkm_lane u_lane (
      .shift    (modifiers[ShiftModBit]),
      .code     (codes[l]),
      .lane_out (lanes[l])
    );
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  hidkm_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .read_address (read_address),
    .lanes        (lanes),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_stall) begin
      // output transfer this cycle
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_res <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_res   <= result;
        out_valid <= 1'b1;
      end
    end else if (accept) begin
      skid_res   <= result;
      skid_valid <= 1'b1;
    end
  end

  assign read_data = out_res.read_data;
  assign changed   = out_res.changed;
  assign pending   = out_res.pending;

endmodule
